FILE: hdl/spq_pkg.sv
package spq_pkg;

    // fixed field widths of the two channels
    localparam int unsigned MODE_W  = 2;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned PRIO_W  = 3;
    localparam int unsigned POS_W   = 6;
    localparam int unsigned LVLO_W  = 3;
    localparam int unsigned STAT_W  = 2;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_PUSH = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POP  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TOP  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_PEEK = 2'd3;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;
    localparam logic [STAT_W-1:0] ST_BEYOND = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0]         mode;
        logic signed [VALUE_W-1:0] data_in;
        logic [PRIO_W-1:0]         priority_req;
        logic [POS_W-1:0]          position;
    } t_in_beat;

    typedef struct packed {
        logic signed [VALUE_W-1:0] result_value;
        logic [LVLO_W-1:0]         result_level;
        logic [STAT_W-1:0]         status;
    } t_out_beat;

    // result handed from the controller to the output stage
    typedef struct packed {
        logic              valid;
        logic              use_ram;
        logic [LVLO_W-1:0] level;
        logic [STAT_W-1:0] status;
    } t_res_req;

endpackage

FILE: hdl/strict_priority_multi_fifo_top.sv
// Push and empty results pass from the input beat through the EXEC and RESULT
// states into the output register; pop, top and positional peek stay in EXEC
// while the top-down walk over the level counters skips levels.
// Only one operation is in flight; the next beat is taken once the controller is
// back in IDLE, after the result has moved into the output register.
// Reset clears all level heads and counts; the entry RAM is not cleared.
module strict_priority_multi_fifo_top #(
    parameter int unsigned LEVELS      = 4,
    parameter int unsigned LEVEL_DEPTH = 16,
    parameter int unsigned DATA_WIDTH  = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  spq_pkg::t_in_beat  i_in_beat,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output spq_pkg::t_out_beat o_out_beat
);

    localparam int unsigned ADDR_W = $clog2(LEVELS * LEVEL_DEPTH);

    spq_pkg::t_res_req                  req;
    logic                               take;
    logic                               we;
    logic                               re;
    logic [ADDR_W-1:0]                  waddr;
    logic [ADDR_W-1:0]                  raddr;
    logic [DATA_WIDTH-1:0]              wdata;
    logic [DATA_WIDTH-1:0]              rdata;
    logic signed [spq_pkg::VALUE_W-1:0] rd_val;
    logic                               r_out_valid;
    spq_pkg::t_out_beat                 r_out;

    spq_ctrl #(
        .LEVELS      (LEVELS),
        .LEVEL_DEPTH (LEVEL_DEPTH),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_beat  (i_in_beat),
        .o_req      (req),
        .i_take     (take),
        .o_we       (we),
        .o_waddr    (waddr),
        .o_wdata    (wdata),
        .o_re       (re),
        .o_raddr    (raddr)
    );

    spq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (LEVELS * LEVEL_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // stored word back to a 32-bit signed value
    generate
        if (DATA_WIDTH >= spq_pkg::VALUE_W) begin : g_wide
            assign rd_val = rdata[spq_pkg::VALUE_W-1:0];
        end else begin : g_narrow
            assign rd_val = {{(spq_pkg::VALUE_W - DATA_WIDTH){rdata[DATA_WIDTH-1]}}, rdata};
        end
    endgenerate

    // output register: loads when empty or when its beat leaves
    assign take = req.valid && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out.result_value <= req.use_ram ? rd_val : '0;
            r_out.result_level <= req.level;
            r_out.status       <= req.status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

endmodule

FILE: hdl/spq_ram.sv
module spq_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port; read data holds without a read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/spq_ctrl.sv
module spq_ctrl #(
    parameter int unsigned LEVELS      = 4,
    parameter int unsigned LEVEL_DEPTH = 16,
    parameter int unsigned DATA_WIDTH  = 32
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_in_valid,
    output logic                                      o_in_ready,
    input  spq_pkg::t_in_beat                         i_in_beat,
    output spq_pkg::t_res_req                         o_req,
    input  logic                                      i_take,
    output logic                                      o_we,
    output logic [$clog2(LEVELS*LEVEL_DEPTH)-1:0]     o_waddr,
    output logic [DATA_WIDTH-1:0]                     o_wdata,
    output logic                                      o_re,
    output logic [$clog2(LEVELS*LEVEL_DEPTH)-1:0]     o_raddr
);

    localparam int unsigned LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int unsigned SLOT_W = $clog2(LEVEL_DEPTH);
    localparam int unsigned CNT_W  = $clog2(LEVEL_DEPTH + 1);
    localparam int unsigned CMP_W  = (CNT_W > spq_pkg::POS_W) ? CNT_W : spq_pkg::POS_W;
    localparam int unsigned ADDR_W = $clog2(LEVELS * LEVEL_DEPTH);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EXEC   = 2'd1;
    localparam logic [1:0] S_RESULT = 2'd2;

    logic [1:0]                  r_state, n_state;
    spq_pkg::t_in_beat           r_beat, n_beat;
    logic [LVL_W-1:0]            r_lvl, n_lvl;
    logic [CMP_W-1:0]            r_idx, n_idx;
    logic                        r_prio_ok, n_prio_ok;
    logic [SLOT_W-1:0]           r_head [LEVELS];
    logic [SLOT_W-1:0]           n_head [LEVELS];
    logic [CNT_W-1:0]            r_count [LEVELS];
    logic [CNT_W-1:0]            n_count [LEVELS];
    logic                        r_use_ram, n_use_ram;
    logic [spq_pkg::LVLO_W-1:0]  r_res_level, n_res_level;
    logic [spq_pkg::STAT_W-1:0]  r_res_status, n_res_status;

    logic [SLOT_W-1:0]           cur_head;
    logic [CNT_W-1:0]            cur_count;
    logic                        any_nonempty;
    logic                        is_push;
    logic                        hit;
    logic [CMP_W-1:0]            off_sel;
    logic [CMP_W:0]              slot_sum;
    logic [CMP_W:0]              slot_wrap;
    logic [SLOT_W-1:0]           slot;
    logic [SLOT_W:0]             head_sum;
    logic [SLOT_W-1:0]           head_inc;
    logic [ADDR_W-1:0]           addr;

    // per-level pointers for the level under work
    assign cur_head  = r_head[r_lvl];
    assign cur_count = r_count[r_lvl];
    assign is_push   = (r_beat.mode == spq_pkg::MODE_PUSH);
    assign hit       = (r_idx < CMP_W'(cur_count));

    always_comb begin
        any_nonempty = 1'b0;
        for (int l = 0; l < int'(LEVELS); l++) begin
            any_nonempty = any_nonempty | (r_count[l] != '0);
        end
    end

    // slot = (head + offset) mod depth; offset is below depth when used
    assign off_sel   = is_push ? CMP_W'(cur_count) : r_idx;
    assign slot_sum  = (CMP_W + 1)'(cur_head) + (CMP_W + 1)'(off_sel);
    assign slot_wrap = (slot_sum >= (CMP_W + 1)'(LEVEL_DEPTH))
                       ? slot_sum - (CMP_W + 1)'(LEVEL_DEPTH) : slot_sum;
    assign slot      = slot_wrap[SLOT_W-1:0];
    assign addr      = ADDR_W'(r_lvl) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(slot);

    // head advance on pop
    assign head_sum  = (SLOT_W + 1)'(cur_head) + (SLOT_W + 1)'(1);
    assign head_inc  = (head_sum == (SLOT_W + 1)'(LEVEL_DEPTH)) ? '0 : head_sum[SLOT_W-1:0];

    // stored word: input cut or sign-extended to the storage width
    generate
        if (DATA_WIDTH >= spq_pkg::VALUE_W) begin : g_wide
            assign o_wdata = DATA_WIDTH'(r_beat.data_in);
        end else begin : g_narrow
            assign o_wdata = r_beat.data_in[DATA_WIDTH-1:0];
        end
    endgenerate

    // sequencer: accept, walk levels top down, hand over result
    always_comb begin
        n_state      = r_state;
        n_beat       = r_beat;
        n_lvl        = r_lvl;
        n_idx        = r_idx;
        n_prio_ok    = r_prio_ok;
        n_head       = r_head;
        n_count      = r_count;
        n_use_ram    = r_use_ram;
        n_res_level  = r_res_level;
        n_res_status = r_res_status;
        o_we         = 1'b0;
        o_re         = 1'b0;
        o_waddr      = addr;
        o_raddr      = addr;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_beat    = i_in_beat;
                    n_prio_ok = (i_in_beat.priority_req != '0) &&
                                (32'(i_in_beat.priority_req) <= 32'(LEVELS));
                    if (i_in_beat.mode == spq_pkg::MODE_PUSH) begin
                        n_lvl = n_prio_ok ? LVL_W'(32'(i_in_beat.priority_req) - 1) : '0;
                    end else begin
                        n_lvl = LVL_W'(LEVELS - 1);
                    end
                    n_idx = (i_in_beat.mode == spq_pkg::MODE_PEEK)
                            ? CMP_W'(i_in_beat.position) : '0;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_use_ram    = 1'b0;
                n_res_level  = '0;
                n_res_status = spq_pkg::ST_OK;
                if (is_push) begin
                    if (!r_prio_ok || cur_count >= CNT_W'(LEVEL_DEPTH)) begin
                        n_res_status = spq_pkg::ST_FULL;
                    end else begin
                        o_we           = 1'b1;
                        n_count[r_lvl] = cur_count + CNT_W'(1);
                    end
                    n_state = S_RESULT;
                end else if (!any_nonempty) begin
                    n_res_status = spq_pkg::ST_EMPTY;
                    n_state      = S_RESULT;
                end else if (hit) begin
                    o_re        = 1'b1;
                    n_use_ram   = 1'b1;
                    n_res_level = spq_pkg::LVLO_W'(32'(r_lvl) + 1);
                    if (r_beat.mode == spq_pkg::MODE_POP) begin
                        n_head[r_lvl]  = head_inc;
                        n_count[r_lvl] = cur_count - CNT_W'(1);
                    end
                    n_state = S_RESULT;
                end else if (r_lvl == '0) begin
                    n_res_status = spq_pkg::ST_BEYOND;
                    n_state      = S_RESULT;
                end else begin
                    // skip this level's entries, move one level down
                    n_idx = r_idx - CMP_W'(cur_count);
                    n_lvl = r_lvl - LVL_W'(1);
                end
            end
            S_RESULT: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            for (int l = 0; l < int'(LEVELS); l++) begin
                r_head[l]  <= '0;
                r_count[l] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    // working registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_beat       <= n_beat;
        r_lvl        <= n_lvl;
        r_idx        <= n_idx;
        r_prio_ok    <= n_prio_ok;
        r_use_ram    <= n_use_ram;
        r_res_level  <= n_res_level;
        r_res_status <= n_res_status;
    end

    // no beat is taken while reset is held
    assign o_in_ready    = i_rst_n && (r_state == S_IDLE);
    assign o_req.valid   = (r_state == S_RESULT);
    assign o_req.use_ram = r_use_ram;
    assign o_req.level   = r_res_level;
    assign o_req.status  = r_res_status;

endmodule

FILE: tb/strict_priority_multi_fifo_top_tb.sv
module strict_priority_multi_fifo_top_tb;

    localparam int LVL_N       = 4;
    localparam int LVL_DEPTH   = 16;
    localparam int RANDOM_OPS  = 1125;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_TAIL  = 16;

    // mirror of the four level FIFOs plus the results still owed by the block
    class prio_queue_ledger;
        logic signed [spq_pkg::VALUE_W-1:0] words [LVL_N][LVL_DEPTH];
        int                                 head  [LVL_N];
        int                                 count [LVL_N];
        spq_pkg::t_out_beat                 results_due [$];
        int                                 mismatches;

        function int stored_total();
            int sum;
            sum = 0;
            for (int lv = 0; lv < LVL_N; lv++) sum += count[lv];
            return sum;
        endfunction

        // apply one accepted operation and queue the result it must produce
        function void note_op(spq_pkg::t_in_beat b);
            spq_pkg::t_out_beat r;
            int                 lv;
            int                 idx;
            bit                 found;
            r        = '0;
            r.status = spq_pkg::ST_OK;
            case (b.mode)
                spq_pkg::MODE_PUSH: begin
                    if (b.priority_req == 0 || b.priority_req > LVL_N) begin
                        r.status = spq_pkg::ST_FULL;
                    end else begin
                        lv = b.priority_req - 1;
                        if (count[lv] == LVL_DEPTH) begin
                            r.status = spq_pkg::ST_FULL;
                        end else begin
                            words[lv][(head[lv] + count[lv]) % LVL_DEPTH] = b.data_in;
                            count[lv]++;
                        end
                    end
                end
                spq_pkg::MODE_POP, spq_pkg::MODE_TOP: begin
                    lv = LVL_N - 1;
                    while (lv >= 0 && count[lv] == 0) lv--;
                    if (lv < 0) begin
                        r.status = spq_pkg::ST_EMPTY;
                    end else begin
                        r.result_value = words[lv][head[lv]];
                        r.result_level = spq_pkg::LVLO_W'(lv + 1);
                        if (b.mode == spq_pkg::MODE_POP) begin
                            head[lv] = (head[lv] + 1) % LVL_DEPTH;
                            count[lv]--;
                        end
                    end
                end
                default: begin
                    // positional walk: highest level first, front to back
                    if (stored_total() == 0) begin
                        r.status = spq_pkg::ST_EMPTY;
                    end else begin
                        idx   = b.position;
                        found = 1'b0;
                        for (lv = LVL_N - 1; lv >= 0; lv--) begin
                            if (!found) begin
                                if (idx < count[lv]) begin
                                    r.result_value = words[lv][(head[lv] + idx) % LVL_DEPTH];
                                    r.result_level = spq_pkg::LVLO_W'(lv + 1);
                                    found = 1'b1;
                                end else begin
                                    idx -= count[lv];
                                end
                            end
                        end
                        if (!found) r.status = spq_pkg::ST_BEYOND;
                    end
                end
            endcase
            results_due.push_back(r);
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("MISMATCH: %s", what);
        endtask

        task check_answer(spq_pkg::t_out_beat got);
            spq_pkg::t_out_beat want;
            if (results_due.size() == 0) begin
                report_mismatch($sformatf("result beat with nothing owed (value %0d)",
                                          got.result_value));
                return;
            end
            want = results_due.pop_front();
            if (got.result_value !== want.result_value)
                report_mismatch($sformatf("value %0d, want %0d",
                                          got.result_value, want.result_value));
            if (got.result_level !== want.result_level)
                report_mismatch($sformatf("level %0d, want %0d",
                                          got.result_level, want.result_level));
            if (got.status !== want.status)
                report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
        endtask
    endclass

    logic               i_clk     = 1'b0;
    logic               i_rst_n   = 1'b0;
    logic               in_valid  = 1'b0;
    spq_pkg::t_in_beat  in_beat   = '0;
    logic               out_ready = 1'b0;
    logic               o_in_ready;
    logic               o_out_valid;
    spq_pkg::t_out_beat o_out_beat;

    prio_queue_ledger sb = new;

    int idle_cycles = 0;
    int stall_left  = 0;
    int stall_style = 0;
    int style_left  = 0;

    strict_priority_multi_fifo_top #(
        .LEVELS      (LVL_N),
        .LEVEL_DEPTH (LVL_DEPTH),
        .DATA_WIDTH  (spq_pkg::VALUE_W)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_beat   (in_beat),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_beat  (o_out_beat)
    );

    always #2 i_clk = ~i_clk;

    // check result beats first, then log the input beat taken on the same edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && out_ready) sb.check_answer(o_out_beat);
        if (i_rst_n && in_valid && o_in_ready) sb.note_op(in_beat);
    end

    // receiver back-pressure: switches between always-ready, choppy and long stalls
    always @(posedge i_clk) begin
        if (style_left == 0) begin
            stall_style <= $urandom_range(2);
            style_left  <= $urandom_range(50, 300);
        end else begin
            style_left <= style_left - 1;
        end
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end else begin
            case (stall_style)
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(3) != 0);
                default: begin
                    if ($urandom_range(7) == 0) begin
                        out_ready  <= 1'b0;
                        stall_left <= $urandom_range(3, 12);
                    end else begin
                        out_ready <= 1'b1;
                    end
                end
            endcase
        end
    end

    // watchdog on cycles with no beat moving on either side
    always @(posedge i_clk) begin
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (i_rst_n) begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic spq_pkg::t_in_beat op_beat(logic [spq_pkg::MODE_W-1:0] mode,
                                                  logic signed [spq_pkg::VALUE_W-1:0] data,
                                                  int prio, int pos);
        spq_pkg::t_in_beat b;
        b.mode         = mode;
        b.data_in      = data;
        b.priority_req = spq_pkg::PRIO_W'(prio);
        b.position     = spq_pkg::POS_W'(pos);
        return b;
    endfunction

    // random operation; push share and favoured level come from the current segment
    function automatic spq_pkg::t_in_beat pick_random_op(int push_pct, int fav_level);
        spq_pkg::t_in_beat b;
        int                total;
        int                roll;
        int                prio;
        b.data_in  = $urandom;
        if ($urandom_range(99) < 15) begin
            case ($urandom_range(4))
                0: b.data_in = 32'sh8000_0000;
                1: b.data_in = 32'sh7fff_ffff;
                2: b.data_in = 0;
                3: b.data_in = -1;
                default: b.data_in = 1;
            endcase
        end
        if ($urandom_range(19) == 0) begin
            // out-of-range level
            prio = $urandom_range(4, 7);
            if (prio == 4) prio = 0;
        end else if ($urandom_range(1) == 0) begin
            prio = fav_level;
        end else begin
            prio = $urandom_range(1, LVL_N);
        end
        b.priority_req = spq_pkg::PRIO_W'(prio);
        total = sb.stored_total();
        if (total > 0 && $urandom_range(9) < 7)
            b.position = spq_pkg::POS_W'($urandom_range(0, (total > 63) ? 63 : total));
        else
            b.position = spq_pkg::POS_W'($urandom_range(63));
        roll = $urandom_range(99);
        if (roll < push_pct) begin
            b.mode = spq_pkg::MODE_PUSH;
        end else begin
            roll = $urandom_range(9);
            if (roll < 5)      b.mode = spq_pkg::MODE_POP;
            else if (roll < 7) b.mode = spq_pkg::MODE_TOP;
            else               b.mode = spq_pkg::MODE_PEEK;
        end
        return b;
    endfunction

    task automatic send_op(spq_pkg::t_in_beat b);
        in_beat  <= b;
        in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic rest(int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    initial begin
        int k;
        int seg_left;
        int burst_left;
        int push_pct;
        int fav_level;
        bit no_gaps;
        seg_left   = 0;
        burst_left = 0;
        push_pct   = 50;
        fav_level  = 1;
        no_gaps    = 1'b0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // everything empty
        send_op(op_beat(spq_pkg::MODE_POP,  0, 0, 0));
        send_op(op_beat(spq_pkg::MODE_TOP,  -1, 7, 63));
        send_op(op_beat(spq_pkg::MODE_PEEK, 0, 0, 0));
        // invalid levels are dropped like a full level
        send_op(op_beat(spq_pkg::MODE_PUSH, 32'sh1234_5678, 0, 0));
        send_op(op_beat(spq_pkg::MODE_PUSH, 32'sh1234_5678, 7, 0));
        send_op(op_beat(spq_pkg::MODE_PUSH, 32'sh1234_5678, 5, 0));
        // one or two words on every level, extreme values
        send_op(op_beat(spq_pkg::MODE_PUSH, 32'sh8000_0000, 1, 0));
        send_op(op_beat(spq_pkg::MODE_PUSH, 32'sh7fff_ffff, 2, 0));
        send_op(op_beat(spq_pkg::MODE_PUSH, -1, 3, 0));
        send_op(op_beat(spq_pkg::MODE_PUSH, 0, 4, 0));
        send_op(op_beat(spq_pkg::MODE_PUSH, 1, 1, 0));
        send_op(op_beat(spq_pkg::MODE_TOP,  0, 0, 0));
        // positional walk: front, last entry, just beyond, far beyond
        send_op(op_beat(spq_pkg::MODE_PEEK, 0, 0, 0));
        send_op(op_beat(spq_pkg::MODE_PEEK, 0, 0, 4));
        send_op(op_beat(spq_pkg::MODE_PEEK, 0, 0, 5));
        send_op(op_beat(spq_pkg::MODE_PEEK, 0, 0, 63));
        // drain in priority order
        send_op(op_beat(spq_pkg::MODE_POP,  0, 0, 0));
        send_op(op_beat(spq_pkg::MODE_POP,  0, 0, 0));
        send_op(op_beat(spq_pkg::MODE_TOP,  0, 0, 0));
        send_op(op_beat(spq_pkg::MODE_POP,  0, 0, 0));
        send_op(op_beat(spq_pkg::MODE_POP,  0, 0, 0));
        send_op(op_beat(spq_pkg::MODE_POP,  0, 0, 0));
        send_op(op_beat(spq_pkg::MODE_POP,  0, 0, 0));
        send_op(op_beat(spq_pkg::MODE_PEEK, 0, 0, 63));

        // random segments, each with its own push share, favoured level and gap habit
        for (k = 0; k < RANDOM_OPS; k++) begin
            if (seg_left == 0) begin
                seg_left  = $urandom_range(20, 60);
                case ($urandom_range(3))
                    0: push_pct = 15;
                    1: push_pct = 40;
                    2: push_pct = 60;
                    default: push_pct = 85;
                endcase
                fav_level = $urandom_range(1, LVL_N);
                no_gaps   = ($urandom_range(3) == 0);
            end
            seg_left--;
            if (burst_left == 0) begin
                if (!no_gaps) rest($urandom_range(1, 8));
                burst_left = $urandom_range(1, 20);
            end
            burst_left--;
            send_op(pick_random_op(push_pct, fav_level));
        end
        in_valid <= 1'b0;

        while (sb.results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_TAIL) @(posedge i_clk);
        if (sb.results_due.size() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.results_due.size()));

        if (sb.mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

FILE: files.f
hdl/spq_pkg.sv
hdl/spq_ram.sv
hdl/spq_ctrl.sv
hdl/strict_priority_multi_fifo_top.sv
tb/strict_priority_multi_fifo_top_tb.sv
